// ----- rtl/stok_pkg.sv -----
`timescale 1ns / 1ps

package stok_pkg;

  localparam int unsigned BUFFER_BYTES = 65536;
  localparam int unsigned POS_W        = $clog2(BUFFER_BYTES) + 1;

  localparam int unsigned OFS_W = 16;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned RC_W  = 16;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH) + 1;

  typedef enum logic [3:0] {
    KIND_LPAREN   = 4'd0,
    KIND_RPAREN   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_LBRACE   = 4'd4,
    KIND_RBRACE   = 4'd5,
    KIND_QUOTE    = 4'd6,
    KIND_STRING   = 4'd7,
    KIND_UNCLOSED = 4'd8,
    KIND_INT      = 4'd9,
    KIND_FLOAT    = 4'd10,
    KIND_IDENT    = 4'd11
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [OFS_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic [RC_W-1:0]   row;
    logic [RC_W-1:0]   col;
    logic              last;
  } tok_t;

  typedef struct packed {
    logic [1:0] num;
    tok_t       tok0;
    tok_t       tok1;
  } tok_pair_t;

endpackage

// ----- rtl/stok_front.sv -----
`timescale 1ns / 1ps

module stok_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_byte_i,
  input  logic                buffer_end_i,
  output stok_pkg::tok_pair_t pair_o
);

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_COMMENT = 7'b0000010,
    MODE_STRING  = 7'b0000100,
    MODE_INT     = 7'b0001000,
    MODE_FLOAT   = 7'b0010000,
    MODE_IDENT   = 7'b0100000,
    MODE_HALT    = 7'b1000000
  } mode_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  localparam int unsigned POS_W = stok_pkg::POS_W;
  localparam int unsigned RC_W  = stok_pkg::RC_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(stok_pkg::BUFFER_BYTES - 1);
  localparam logic [RC_W-1:0]  RC_ONE   = RC_W'(1);

  function automatic logic [RC_W-1:0] sat_add(input logic [RC_W-1:0] a,
                                              input logic [2:0] b);
    logic [RC_W:0] s;
    s = {1'b0, a} + (RC_W+1)'(b);
    return s[RC_W] ? {RC_W{1'b1}} : s[RC_W-1:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic ends_ident(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) ||
           (c == CH_LPAR) || (c == CH_RPAR);
  endfunction

  mode_e            mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] ts_q, ts_d;
  logic [RC_W-1:0]  tr_q, tr_d, tc_q, tc_d, cr_q, cr_d, cc_q, cc_d;

  logic             last;
  logic             reex;
  logic [POS_W-1:0] endp;
  logic [POS_W-1:0] ustart;
  logic             a_v, b_v, c_v;
  stok_pkg::tok_t   tok_a, tok_b, tok_c;

  always_comb begin
    mode_d = mode_q;
    ts_d   = ts_q;
    tr_d   = tr_q;
    tc_d   = tc_q;
    cr_d   = cr_q;
    cc_d   = cc_q;
    pos_d  = pos_q;
    reex   = 1'b0;
    a_v    = 1'b0;
    b_v    = 1'b0;
    c_v    = 1'b0;
    last   = buffer_end_i || (pos_q == POS_LAST);
    endp   = pos_q + POS_W'(1);
    ustart = '0;

    tok_a       = '0;
    tok_a.start = stok_pkg::OFS_W'(ts_q);
    tok_a.len   = stok_pkg::LEN_W'(pos_q - ts_q);
    tok_a.row   = tr_q;
    tok_a.col   = tc_q;
    tok_a.kind  = stok_pkg::KIND_IDENT;
    tok_b       = '0;
    tok_b.kind  = stok_pkg::KIND_LPAREN;
    tok_c       = '0;
    tok_c.kind  = stok_pkg::KIND_IDENT;

    case (mode_q)
      MODE_INT: begin
        if (is_digit(char_byte_i)) begin
          cc_d = sat_add(cc_q, 3'd1);
        end else if (char_byte_i == CH_DOT) begin
          mode_d = MODE_FLOAT;
          cc_d   = sat_add(cc_q, 3'd1);
        end else begin
          a_v        = 1'b1;
          tok_a.kind = stok_pkg::KIND_INT;
          reex       = 1'b1;
        end
      end
      MODE_FLOAT: begin
        if (is_digit(char_byte_i)) begin
          cc_d = sat_add(cc_q, 3'd1);
        end else begin
          a_v        = 1'b1;
          tok_a.kind = stok_pkg::KIND_FLOAT;
          reex       = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!ends_ident(char_byte_i)) begin
          cc_d = sat_add(cc_q, 3'd1);
        end else begin
          a_v        = 1'b1;
          tok_a.kind = stok_pkg::KIND_IDENT;
          reex       = 1'b1;
        end
      end
      MODE_STRING: begin
        if (char_byte_i == CH_DQUOT) begin
          a_v        = 1'b1;
          tok_a.kind = stok_pkg::KIND_STRING;
          mode_d     = MODE_IDLE;
        end
        cc_d = sat_add(cc_q, 3'd1);
      end
      MODE_COMMENT: begin
        if (char_byte_i == CH_NL) begin
          reex = 1'b1;
        end else begin
          cc_d = sat_add(cc_q, 3'd1);
        end
      end
      MODE_HALT: begin
      end
      default: begin
        reex = 1'b1;
      end
    endcase

    // byte seen between tokens
    if (reex) begin
      mode_d      = MODE_IDLE;
      tok_b.start = stok_pkg::OFS_W'(pos_q);
      tok_b.len   = stok_pkg::LEN_W'(1);
      tok_b.row   = cr_q;
      tok_b.col   = cc_q;
      case (char_byte_i)
        CH_SPACE: cc_d = sat_add(cc_q, 3'd1);
        CH_TAB:   cc_d = sat_add(cc_q, 3'd4);
        CH_NL: begin
          cr_d = sat_add(cr_q, 3'd1);
          cc_d = RC_ONE;
        end
        CH_LPAR: begin
          b_v        = 1'b1;
          tok_b.kind = stok_pkg::KIND_LPAREN;
        end
        CH_RPAR: begin
          b_v        = 1'b1;
          tok_b.kind = stok_pkg::KIND_RPAREN;
        end
        CH_LBRK: begin
          b_v        = 1'b1;
          tok_b.kind = stok_pkg::KIND_LBRACKET;
        end
        CH_RBRK: begin
          b_v        = 1'b1;
          tok_b.kind = stok_pkg::KIND_RBRACKET;
        end
        CH_LBRC: begin
          b_v        = 1'b1;
          tok_b.kind = stok_pkg::KIND_LBRACE;
        end
        CH_RBRC: begin
          b_v        = 1'b1;
          tok_b.kind = stok_pkg::KIND_RBRACE;
        end
        CH_SQUOT: begin
          b_v        = 1'b1;
          tok_b.kind = stok_pkg::KIND_QUOTE;
        end
        CH_DQUOT: begin
          mode_d = MODE_STRING;
          ts_d   = endp;
          tr_d   = cr_q;
          tc_d   = cc_q;
          cc_d   = sat_add(cc_q, 3'd1);
        end
        CH_SEMI: begin
          mode_d = MODE_COMMENT;
          cc_d   = sat_add(cc_q, 3'd1);
        end
        CH_NUL: mode_d = MODE_HALT;
        default: begin
          mode_d = is_digit(char_byte_i) ? MODE_INT : MODE_IDENT;
          ts_d   = pos_q;
          tr_d   = cr_q;
          tc_d   = cc_q;
          cc_d   = sat_add(cc_q, 3'd1);
        end
      endcase
      if (b_v) begin
        cc_d = sat_add(cc_q, 3'd1);
      end
    end

    // flush at end of buffer
    ustart      = ts_d - POS_W'(1);
    tok_c.start = stok_pkg::OFS_W'(ts_d);
    tok_c.len   = stok_pkg::LEN_W'(endp - ts_d);
    tok_c.row   = tr_d;
    tok_c.col   = tc_d;
    if (last) begin
      case (mode_d)
        MODE_INT: begin
          c_v        = 1'b1;
          tok_c.kind = stok_pkg::KIND_INT;
        end
        MODE_FLOAT: begin
          c_v        = 1'b1;
          tok_c.kind = stok_pkg::KIND_FLOAT;
        end
        MODE_IDENT: begin
          c_v        = 1'b1;
          tok_c.kind = stok_pkg::KIND_IDENT;
        end
        MODE_STRING: begin
          c_v         = 1'b1;
          tok_c.kind  = stok_pkg::KIND_UNCLOSED;
          tok_c.start = stok_pkg::OFS_W'(ustart);
          tok_c.len   = stok_pkg::LEN_W'(endp - ustart);
        end
        default: c_v = 1'b0;
      endcase
      mode_d = MODE_IDLE;
      pos_d  = '0;
      ts_d   = '0;
      tr_d   = RC_ONE;
      tc_d   = RC_ONE;
      cr_d   = RC_ONE;
      cc_d   = RC_ONE;
    end else begin
      pos_d = endp;
    end
  end

  always_comb begin
    pair_o.num       = accept_i ? (2'(a_v) + 2'(b_v) + 2'(c_v)) : 2'd0;
    pair_o.tok0      = a_v ? tok_a : (b_v ? tok_b : tok_c);
    pair_o.tok1      = a_v ? (b_v ? tok_b : tok_c) : tok_c;
    pair_o.tok0.last = (2'(a_v) + 2'(b_v) + 2'(c_v)) == 2'd1;
    pair_o.tok1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      ts_q   <= '0;
      tr_q   <= RC_ONE;
      tc_q   <= RC_ONE;
      cr_q   <= RC_ONE;
      cc_q   <= RC_ONE;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      ts_q   <= ts_d;
      tr_q   <= tr_d;
      tc_q   <= tc_d;
      cr_q   <= cr_d;
      cc_q   <= cc_d;
    end
  end

endmodule

// ----- rtl/stok_queue.sv -----
`timescale 1ns / 1ps

module stok_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stok_pkg::tok_pair_t pair_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stok_pkg::tok_t      out_tok_o
);

  localparam int unsigned QDEPTH = stok_pkg::QDEPTH;
  localparam int unsigned QPTR_W = stok_pkg::QPTR_W;
  localparam int unsigned QCNT_W = stok_pkg::QCNT_W;

  stok_pkg::tok_t    mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rp_q];
  assign room_o      = cnt_q <= QCNT_W'(QDEPTH - 2);

  always_comb begin
    wp_d  = wp_q + QPTR_W'(pair_i.num);
    rp_d  = rp_q + QPTR_W'(pop);
    cnt_d = cnt_q + QCNT_W'(pair_i.num) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (pair_i.num != 2'd0) begin
      mem_q[wp_q] <= pair_i.tok0;
    end
    if (pair_i.num == 2'd2) begin
      mem_q[QPTR_W'(wp_q + QPTR_W'(1))] <= pair_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/s_expression_tokenizer_top.sv -----
`timescale 1ns / 1ps

// Streaming lexer for a Lisp-style language. One source byte is taken per cycle
// when in_stall_o is low; a token enters the queue as the byte completing it is
// accepted. A byte causes at most two tokens, which go into a four-entry queue
// drained at one token per cycle while out_stall_i is low. The input stalls while
// fewer than two queue entries are free, so a sustained rate of one byte per cycle
// holds as long as the output is not stalled. last_of_run marks the final token
// caused by one byte. State resets after a buffer_end byte or offset 65535.

module s_expression_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [16:0] value_length_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic        last_of_run_o
);

  stok_pkg::tok_pair_t pair;
  stok_pkg::tok_t      out_tok;
  logic                room;
  logic                accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  stok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_byte_i  (char_byte_i),
    .buffer_end_i (buffer_end_i),
    .pair_o       (pair)
  );

  stok_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pair),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tok_o   (out_tok)
  );

  assign token_kind_o    = out_tok.kind;
  assign start_offset_o  = out_tok.start;
  assign value_length_o  = out_tok.len;
  assign line_number_o   = out_tok.row;
  assign column_number_o = out_tok.col;
  assign last_of_run_o   = out_tok.last;

endmodule

// ----- rtl/stok_checker.sv -----
`timescale 1ns / 1ps

module stok_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_byte_i,
  input logic        buffer_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  token_kind_o,
  input logic [15:0] start_offset_o,
  input logic [16:0] value_length_o,
  input logic [15:0] line_number_o,
  input logic [15:0] column_number_o,
  input logic        last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(token_kind_o) && $stable(start_offset_o) &&
      $stable(value_length_o) && $stable(last_of_run_o))
    else $error("output item changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= 4'(stok_pkg::KIND_IDENT))
    else $error("token kind out of range");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_number_o != 16'd0) && (column_number_o != 16'd0))
    else $error("row or column is zero");

  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o <= 4'(stok_pkg::KIND_QUOTE)) |->
      value_length_o == 17'd1)
    else $error("single-byte token with wrong length");

endmodule

bind s_expression_tokenizer_top stok_checker u_stok_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

localparam logic [7:0] CH_NUL      = 8'h00;
localparam logic [7:0] CH_TAB      = 8'h09;
localparam logic [7:0] CH_LF       = 8'h0A;
localparam logic [7:0] CH_VT       = 8'h0B;
localparam logic [7:0] CH_FF       = 8'h0C;
localparam logic [7:0] CH_CR       = 8'h0D;
localparam logic [7:0] CH_SPACE    = 8'h20;
localparam logic [7:0] CH_DQUOTE   = 8'h22;
localparam logic [7:0] CH_QUOTE    = 8'h27;
localparam logic [7:0] CH_LPAREN   = 8'h28;
localparam logic [7:0] CH_RPAREN   = 8'h29;
localparam logic [7:0] CH_DOT      = 8'h2E;
localparam logic [7:0] CH_ZERO     = 8'h30;
localparam logic [7:0] CH_NINE     = 8'h39;
localparam logic [7:0] CH_SEMI     = 8'h3B;
localparam logic [7:0] CH_LBRACKET = 8'h5B;
localparam logic [7:0] CH_RBRACKET = 8'h5D;
localparam logic [7:0] CH_LBRACE   = 8'h7B;
localparam logic [7:0] CH_RBRACE   = 8'h7D;

localparam int unsigned MAX_PRINTED = 40;

typedef enum logic [2:0] {
  SCAN_IDLE,
  SCAN_COMMENT,
  SCAN_STRING,
  SCAN_INT,
  SCAN_FLOAT,
  SCAN_IDENT,
  SCAN_HALT
} scan_e;

class token_tracker;
  scan_e          mode;
  logic [16:0]    pos;
  logic [16:0]    tok_start;
  logic [15:0]    tok_row;
  logic [15:0]    tok_col;
  logic [15:0]    cur_row;
  logic [15:0]    cur_col;
  stok_pkg::tok_t byte_toks[$];
  stok_pkg::tok_t due_tokens[$];
  int unsigned    n_err;
  int unsigned    n_checked;

  function new();
    clear_state();
    n_err     = 0;
    n_checked = 0;
  endfunction

  function void clear_state();
    mode      = SCAN_IDLE;
    pos       = '0;
    tok_start = '0;
    tok_row   = 16'd1;
    tok_col   = 16'd1;
    cur_row   = 16'd1;
    cur_col   = 16'd1;
  endfunction

  function logic [15:0] sat_add(logic [15:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function bit ends_ident(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_LPAREN ||
           c == CH_RPAREN;
  endfunction

  function void add_tok(stok_pkg::kind_e k, logic [16:0] start, logic [16:0] len,
                        logic [15:0] row, logic [15:0] col);
    stok_pkg::tok_t t;
    t.kind  = k;
    t.start = start[15:0];
    t.len   = len;
    t.row   = row;
    t.col   = col;
    t.last  = 1'b0;
    byte_toks.push_back(t);
  endfunction

  function void begin_tok(scan_e m, logic [16:0] start);
    mode      = m;
    tok_start = start;
    tok_row   = cur_row;
    tok_col   = cur_col;
    cur_col   = sat_add(cur_col, 1);
  endfunction

  // byte seen between tokens
  function void idle_byte(logic [7:0] c);
    stok_pkg::kind_e k;
    bit              single;
    single = 1'b0;
    k      = stok_pkg::KIND_LPAREN;
    case (c)
      CH_SPACE: cur_col = sat_add(cur_col, 1);
      CH_TAB: cur_col = sat_add(cur_col, 4);
      CH_LF: begin
        cur_row = sat_add(cur_row, 1);
        cur_col = 16'd1;
      end
      CH_LPAREN: begin k = stok_pkg::KIND_LPAREN; single = 1'b1; end
      CH_RPAREN: begin k = stok_pkg::KIND_RPAREN; single = 1'b1; end
      CH_LBRACKET: begin k = stok_pkg::KIND_LBRACKET; single = 1'b1; end
      CH_RBRACKET: begin k = stok_pkg::KIND_RBRACKET; single = 1'b1; end
      CH_LBRACE: begin k = stok_pkg::KIND_LBRACE; single = 1'b1; end
      CH_RBRACE: begin k = stok_pkg::KIND_RBRACE; single = 1'b1; end
      CH_QUOTE: begin k = stok_pkg::KIND_QUOTE; single = 1'b1; end
      CH_DQUOTE: begin_tok(SCAN_STRING, pos + 17'd1);
      CH_SEMI: begin
        mode    = SCAN_COMMENT;
        cur_col = sat_add(cur_col, 1);
      end
      CH_NUL: mode = SCAN_HALT;
      default: begin
        if (is_digit(c)) begin_tok(SCAN_INT, pos);
        else begin_tok(SCAN_IDENT, pos);
      end
    endcase
    if (single) begin
      add_tok(k, pos, 17'd1, cur_row, cur_col);
      cur_col = sat_add(cur_col, 1);
    end
  endfunction

  function void note_byte(logic [7:0] c, logic end_flag);
    bit          again;
    bit          last_b;
    logic [16:0] endp;
    byte_toks.delete();
    again  = 1'b0;
    last_b = end_flag || (pos + 1 >= stok_pkg::BUFFER_BYTES);
    case (mode)
      SCAN_INT: begin
        if (is_digit(c)) begin
          cur_col = sat_add(cur_col, 1);
        end else if (c == CH_DOT) begin
          mode    = SCAN_FLOAT;
          cur_col = sat_add(cur_col, 1);
        end else begin
          add_tok(stok_pkg::KIND_INT, tok_start, pos - tok_start, tok_row, tok_col);
          again = 1'b1;
        end
      end
      SCAN_FLOAT: begin
        if (is_digit(c)) begin
          cur_col = sat_add(cur_col, 1);
        end else begin
          add_tok(stok_pkg::KIND_FLOAT, tok_start, pos - tok_start, tok_row, tok_col);
          again = 1'b1;
        end
      end
      SCAN_IDENT: begin
        if (!ends_ident(c)) begin
          cur_col = sat_add(cur_col, 1);
        end else begin
          add_tok(stok_pkg::KIND_IDENT, tok_start, pos - tok_start, tok_row, tok_col);
          again = 1'b1;
        end
      end
      SCAN_STRING: begin
        if (c == CH_DQUOTE) begin
          add_tok(stok_pkg::KIND_STRING, tok_start, pos - tok_start, tok_row, tok_col);
          mode = SCAN_IDLE;
        end
        cur_col = sat_add(cur_col, 1);
      end
      SCAN_COMMENT: begin
        if (c == CH_LF) again = 1'b1;
        else cur_col = sat_add(cur_col, 1);
      end
      SCAN_HALT: ;
      default: again = 1'b1;
    endcase
    if (again) begin
      mode = SCAN_IDLE;
      idle_byte(c);
    end
    if (last_b) begin
      endp = pos + 17'd1;
      case (mode)
        SCAN_INT: begin
          add_tok(stok_pkg::KIND_INT, tok_start, endp - tok_start, tok_row, tok_col);
        end
        SCAN_FLOAT: begin
          add_tok(stok_pkg::KIND_FLOAT, tok_start, endp - tok_start, tok_row, tok_col);
        end
        SCAN_IDENT: begin
          add_tok(stok_pkg::KIND_IDENT, tok_start, endp - tok_start, tok_row, tok_col);
        end
        SCAN_STRING: begin
          add_tok(stok_pkg::KIND_UNCLOSED, tok_start - 17'd1,
                  endp - (tok_start - 17'd1), tok_row, tok_col);
        end
        default: ;
      endcase
      clear_state();
    end else begin
      pos = pos + 17'd1;
    end
    if (byte_toks.size() > 0) byte_toks[byte_toks.size() - 1].last = 1'b1;
    foreach (byte_toks[i]) due_tokens.push_back(byte_toks[i]);
  endfunction

  function void check_field(string what, logic [16:0] want_v, logic [16:0] got_v);
    if (got_v !== want_v) begin
      n_err++;
      if (n_err <= MAX_PRINTED)
        $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
    end
  endfunction

  function void check_token(stok_pkg::tok_t got);
    stok_pkg::tok_t want;
    if (due_tokens.size() == 0) begin
      n_err++;
      if (n_err <= MAX_PRINTED)
        $display("%0t: token expected none actual kind %0d start %0d", $time,
                 got.kind, got.start);
      return;
    end
    want = due_tokens.pop_front();
    n_checked++;
    check_field("token_kind", want.kind, got.kind);
    check_field("start_offset", want.start, got.start);
    check_field("value_length", want.len, got.len);
    check_field("line_number", want.row, got.row);
    check_field("column_number", want.col, got.col);
    check_field("last_of_run", want.last, got.last);
  endfunction
endclass

module testbench;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned PHASE_BYTES = 250;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_byte;
  logic        buffer_end;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  token_kind;
  logic [15:0] start_offset;
  logic [16:0] value_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_of_run;

  token_tracker tracker;
  logic [7:0]   src_q[$];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  bytes_sent;
  int unsigned  buffers_sent;
  int unsigned  cycle_count = 0;

  s_expression_tokenizer_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_byte_i    (char_byte),
    .buffer_end_i   (buffer_end),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (token_kind),
    .start_offset_o (start_offset),
    .value_length_o (value_length),
    .line_number_o  (line_number),
    .column_number_o(column_number),
    .last_of_run_o  (last_of_run)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    stok_pkg::tok_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind  = stok_pkg::kind_e'(token_kind);
        got.start = start_offset;
        got.len   = value_length;
        got.row   = line_number;
        got.col   = column_number;
        got.last  = last_of_run;
        tracker.check_token(got);
      end
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(s.len() - 1, 0)];
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic end_b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    char_byte  <= c;
    buffer_end <= end_b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_byte(c, end_b);
    bytes_sent++;
  endtask

  task automatic send_buffer(input logic mark_end);
    foreach (src_q[i]) send_byte(src_q[i], mark_end && (i == src_q.size() - 1));
    src_q.delete();
    buffers_sent++;
  endtask

  // mostly well-formed token runs, some raw noise
  task automatic gen_buffer();
    int unsigned n;
    logic [7:0]  b;
    if ($urandom_range(4, 0) == 0) begin
      n = $urandom_range(20, 1);
      repeat (n) src_q.push_back(8'($urandom_range(255, 0)));
      return;
    end
    n = $urandom_range(10, 1);
    repeat (n) begin
      case ($urandom_range(7, 0))
        0: src_q.push_back(pick_from("()[]{}'"));
        1: begin
          src_q.push_back(CH_DQUOTE);
          repeat ($urandom_range(6, 0)) begin
            do b = 8'($urandom_range(255, 0)); while (b == CH_DQUOTE);
            src_q.push_back(b);
          end
          if ($urandom_range(9, 0) != 0) src_q.push_back(CH_DQUOTE);
        end
        2: repeat ($urandom_range(5, 1)) src_q.push_back(pick_from("0123456789"));
        3: begin
          repeat ($urandom_range(3, 1)) src_q.push_back(pick_from("0123456789"));
          src_q.push_back(CH_DOT);
          repeat ($urandom_range(3, 0)) src_q.push_back(pick_from("0123456789"));
        end
        4: begin
          src_q.push_back(pick_from("abxyz+-*/<>=!?_&%"));
          repeat ($urandom_range(5, 0)) begin
            if ($urandom_range(1, 0)) src_q.push_back(pick_from("abz09.;'\"[]{}#"));
            else src_q.push_back(8'($urandom_range(255, 128)));
          end
        end
        5: begin
          src_q.push_back(CH_SEMI);
          repeat ($urandom_range(6, 0)) src_q.push_back(pick_from("ab (\t\"1;"));
          src_q.push_back(CH_LF);
        end
        6: src_q.push_back(pick_from(" \t\n\t  \v\f\015"));
        default: begin
          if ($urandom_range(19, 0) == 0) src_q.push_back(CH_NUL);
          else src_q.push_back(pick_from("\v\f\015"));
        end
      endcase
      if ($urandom_range(3, 0) != 0) src_q.push_back(pick_from(" \t\n()"));
    end
  endtask

  initial begin
    int unsigned phase_start;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    char_byte      = '0;
    buffer_end     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    buffers_sent   = 0;
    tracker        = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every single-byte kind
    add_text("([{'}])");
    send_buffer(1'b1);
    // comment, float ended by a string, unclosed string
    add_text(";c\n7.1\"s");
    send_buffer(1'b1);
    // closed string, tab, cr identifier holding a nul, int flushed at end
    add_text("\"q\"\t\015");
    src_q.push_back(CH_NUL);
    add_text(" 42");
    send_buffer(1'b1);
    // vt and ff identifiers, nul at token start halts output
    src_q.push_back(CH_VT);
    src_q.push_back(CH_FF);
    src_q.push_back(CH_SPACE);
    src_q.push_back(CH_NUL);
    add_text("z");
    src_q.push_back(8'hFF);
    send_buffer(1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 77; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 77; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        gen_buffer();
        send_buffer(1'b1);
      end
    end
    in_valid <= 1'b0;

    while (tracker.due_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d bytes in %0d buffers, compared %0d tokens", bytes_sent,
             buffers_sent, tracker.n_checked);
    $display("covered all token kinds, comments, halts and four idle/stall mixes");
    if (tracker.n_err == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
